>>> hw/rtl/strongly_connected_components_unit_assert.svh
// Assertion macros for the strongly connected components unit.
// Included by the top level; no other dependencies.
`ifndef STRONGLY_CONNECTED_COMPONENTS_UNIT_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the next cycle.
`define SCC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SCC_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/scc_pkg.sv
// Shared types and constants for the strongly connected components unit.
// No dependencies.
package scc_pkg;
   localparam int VertexMax = 64;
   localparam int EdgeMax   = 256;
   localparam int CountW    = 7;
   localparam int VertW     = 6;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CLR   = 9'b000000010,
      ST_ROOT  = 9'b000000100,
      ST_SCAN  = 9'b000001000,
      ST_EVAL  = 9'b000010000,
      ST_POP   = 9'b000100000,
      ST_FIN   = 9'b001000000,
      ST_EMITR = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_visit;    // clear all visited marks
      logic start_p1;     // begin first pass
      logic start_p2;     // begin second pass
      logic root_step;    // try next root / pop finish stack
      logic scan_step;    // issue edge read
      logic eval_step;    // evaluate edge read
      logic pop_step;     // pop walk stack
      logic emit_start;   // start label read out
      logic emit_adv;     // advance read out
      logic done;         // clear edge store
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic root_found;   // a new root was pushed
      logic roots_done;   // pass has no more roots
      logic pass2;        // current pass is second
      logic edge_end;     // top of walk has no more edges
      logic walk_empty;   // walk holds only its top entry
      logic emit_last;    // current output is last
   } stat_type;
endpackage

>>> hw/rtl/scc_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module scc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

>>> hw/rtl/scc_ctrl.sv
// Sequencer for the two depth-first passes and the result read out.
// Depends on scc_pkg.
module scc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              rsp_stall,
   input  scc_pkg::stat_type stat,
   output scc_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);
   import scc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.clr_visit = 1'b1;
               cmd.start_p1  = 1'b1;
               state_in      = ST_ROOT;
            end
         end
         ST_CLR: begin
            cmd.clr_visit = 1'b1;
            cmd.start_p2  = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (stat.roots_done) state_in = stat.pass2 ? ST_EMITR : ST_CLR;
            else if (stat.root_found) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.edge_end) state_in = ST_POP;
            else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_FIN;
            end
         end
         ST_FIN: state_in = ST_EVAL;  // memory read latency
         ST_EVAL: begin
            cmd.eval_step = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_POP: begin
            cmd.pop_step = 1'b1;
            state_in     = ST_SCAN;
            if (stat.walk_empty) state_in = ST_ROOT;
         end
         ST_EMITR: begin
            cmd.emit_start = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.emit_adv = 1'b1;
               if (stat.emit_last) begin
                  cmd.done = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
endmodule

>>> hw/rtl/scc_dpath.sv
// Datapath: edge store, visited marks, walk and finish stacks, labels.
// Depends on scc_pkg and scc_ram.
module scc_dpath #(
   parameter int MaxVertices = scc_pkg::VertexMax,
   parameter int MaxEdges    = scc_pkg::EdgeMax
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [scc_pkg::VertW-1:0]  edge_from,
   input  logic [scc_pkg::VertW-1:0]  edge_to,
   input  logic [scc_pkg::CountW-1:0] vertex_count,
   input  scc_pkg::cmd_type           cmd,
   output scc_pkg::stat_type          stat,
   output logic [scc_pkg::VertW-1:0]  vertex_index,
   output logic [scc_pkg::VertW-1:0]  component_id,
   output logic                       edges_dropped,
   output logic                       last_result
);
   import scc_pkg::*;

   localparam int VCap = (MaxVertices < VertexMax) ? MaxVertices : VertexMax;
   localparam int VW   = $clog2(VCap);
   localparam int EW   = $clog2(MaxEdges);
   localparam int TW   = EW + 1;
   localparam int DW   = VW + 1;
   localparam int SW   = VW + TW;   // walk entry: vertex and edge position

   logic [CountW-1:0] n;
   logic [TW-1:0]     total_ff;
   logic              drop_ff;
   logic              ok_edge;

   logic [EW-1:0]      erd_addr;
   logic [2*VertW-1:0] erd_data;

   logic [VCap-1:0]  visit_ff;
   logic [DW-1:0]    fdep_ff, fdep_in;
   logic [DW-1:0]    wdep_ff, wdep_in;
   logic [VW-1:0]    top_v_ff;
   logic [TW-1:0]    top_p_ff;
   logic             pass2_ff;
   logic [DW-1:0]    root_ff;
   logic [VertW-1:0] lcnt_ff;
   logic [DW-1:0]    emit_ff, emit_in;

   logic          root_avail;
   logic          new_root;
   logic [VW-1:0] cand;

   logic [VertW-1:0] ea, eb, efrom, eto;
   logic             take;

   logic          fin_we;
   logic [VW-1:0] fin_raddr;
   logic [VW-1:0] fin_rd;

   logic          walk_we;
   logic [VW-1:0] walk_waddr, walk_raddr;
   logic [SW-1:0] walk_wdata, walk_rd;

   logic          lab_we;
   logic [VW-1:0] lab_waddr;

   // effective vertex count, saturated into 1..VCap
   always_comb begin
      n = vertex_count;
      if (n == '0) n = CountW'(1);
      if (n > CountW'(VCap)) n = CountW'(VCap);
   end

   assign ok_edge = ({1'b0, edge_from} < n) && ({1'b0, edge_to} < n)
                    && (total_ff < TW'(MaxEdges));

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.done) begin
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (load) begin
         if (ok_edge) total_ff <= total_ff + TW'(1);
         else         drop_ff  <= 1'b1;
      end
   end

   // edge store: source and target side by side
   assign erd_addr = top_p_ff[EW-1:0];
   scc_ram #(.Width(2*VertW), .Depth(MaxEdges)) u_edges (
      .clock  (clock),
      .wr_en  (load && ok_edge),
      .wr_addr(total_ff[EW-1:0]),
      .wr_data({edge_from, edge_to}),
      .rd_addr(erd_addr),
      .rd_data(erd_data)
   );

   // candidate root
   always_comb begin
      if (pass2_ff) begin
         root_avail = (fdep_ff != '0);
         cand       = fin_rd;
      end else begin
         root_avail = (root_ff < DW'(n));
         cand       = root_ff[VW-1:0];
      end
   end
   assign new_root = root_avail && !visit_ff[cand];

   // edge evaluation
   assign ea    = erd_data[2*VertW-1:VertW];
   assign eb    = erd_data[VertW-1:0];
   assign efrom = pass2_ff ? eb : ea;
   assign eto   = pass2_ff ? ea : eb;
   assign take  = ({1'b0, ea} < n) && ({1'b0, eb} < n)
                  && (efrom == VertW'(top_v_ff)) && !visit_ff[eto[VW-1:0]];

   // finish stack, read address follows the next depth so the top is ready
   assign fin_we    = cmd.pop_step && !pass2_ff && (fdep_ff < DW'(VCap));
   assign fin_raddr = fdep_in[VW-1:0] - VW'(1);
   scc_ram #(.Width(VW), .Depth(VCap)) u_finish (
      .clock  (clock),
      .wr_en  (fin_we),
      .wr_addr(fdep_ff[VW-1:0]),
      .wr_data(top_v_ff),
      .rd_addr(fin_raddr),
      .rd_data(fin_rd)
   );

   // walk stack below the top entry; the top lives in top_v_ff/top_p_ff
   assign walk_we    = cmd.eval_step && take && (wdep_ff < DW'(VCap));
   assign walk_waddr = wdep_ff[VW-1:0] - VW'(1);
   assign walk_wdata = {top_v_ff, top_p_ff + TW'(1)};
   assign walk_raddr = wdep_in[VW-1:0] - VW'(2);
   scc_ram #(.Width(SW), .Depth(VCap)) u_walk (
      .clock  (clock),
      .wr_en  (walk_we),
      .wr_addr(walk_waddr),
      .wr_data(walk_wdata),
      .rd_addr(walk_raddr),
      .rd_data(walk_rd)
   );

   // component labels, read ahead at the next emit address
   assign lab_we    = pass2_ff && ((cmd.root_step && new_root) || (cmd.eval_step && take));
   assign lab_waddr = cmd.eval_step ? eto[VW-1:0] : cand;
   scc_ram #(.Width(VertW), .Depth(VCap)) u_labels (
      .clock  (clock),
      .wr_en  (lab_we),
      .wr_addr(lab_waddr),
      .wr_data(lcnt_ff),
      .rd_addr(emit_in[VW-1:0]),
      .rd_data(component_id)
   );

   always_comb begin
      fdep_in = fdep_ff;
      if (cmd.start_p1) fdep_in = '0;
      else if (cmd.root_step && root_avail && pass2_ff) fdep_in = fdep_ff - DW'(1);
      else if (fin_we) fdep_in = fdep_ff + DW'(1);
   end

   always_comb begin
      wdep_in = wdep_ff;
      if (cmd.root_step && new_root) wdep_in = DW'(1);
      else if (walk_we) wdep_in = wdep_ff + DW'(1);
      else if (cmd.pop_step) wdep_in = wdep_ff - DW'(1);
   end

   always_comb begin
      emit_in = emit_ff;
      if (cmd.emit_start) emit_in = '0;
      else if (cmd.emit_adv) emit_in = emit_ff + DW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visit_ff <= '0;
         fdep_ff  <= '0;
         wdep_ff  <= '0;
         top_v_ff <= '0;
         top_p_ff <= '0;
         pass2_ff <= 1'b0;
         root_ff  <= '0;
         lcnt_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         fdep_ff <= fdep_in;
         wdep_ff <= wdep_in;
         emit_ff <= emit_in;
         if (cmd.clr_visit) visit_ff <= '0;
         if (cmd.start_p1) begin
            pass2_ff <= 1'b0;
            root_ff  <= '0;
         end
         if (cmd.start_p2) begin
            pass2_ff <= 1'b1;
            lcnt_ff  <= '0;
         end
         if (cmd.root_step && root_avail && !pass2_ff) root_ff <= root_ff + DW'(1);
         if (cmd.root_step && new_root) begin
            visit_ff[cand] <= 1'b1;
            top_v_ff       <= cand;
            top_p_ff       <= '0;
         end
         if (cmd.eval_step) begin
            if (take) visit_ff[eto[VW-1:0]] <= 1'b1;
            if (walk_we) begin
               top_v_ff <= eto[VW-1:0];
               top_p_ff <= '0;
            end else begin
               top_p_ff <= top_p_ff + TW'(1);
            end
         end
         if (cmd.pop_step) begin
            top_v_ff <= walk_rd[SW-1:TW];
            top_p_ff <= walk_rd[TW-1:0];
            if (pass2_ff && wdep_ff == DW'(1)) lcnt_ff <= lcnt_ff + VertW'(1);
         end
      end
   end

   assign stat.root_found = new_root;
   assign stat.roots_done = !root_avail;
   assign stat.pass2      = pass2_ff;
   assign stat.edge_end   = (top_p_ff >= total_ff);
   assign stat.walk_empty = (wdep_ff == DW'(1));
   assign stat.emit_last  = (emit_ff + DW'(1) == DW'(n));

   assign vertex_index  = VertW'(emit_ff);
   assign edges_dropped = drop_ff;
   assign last_result   = stat.emit_last;
endmodule

>>> hw/rtl/strongly_connected_components_unit.sv
// Top level of the strongly connected components unit (Kosaraju).
// Depends on scc_pkg, scc_ctrl, scc_dpath, scc_ram and the assert header.
//
//   channel | ports                        | direction
//   req     | req_valid/req_stall + fields | in
//   rsp     | rsp_valid/rsp_stall + fields | out
//   csr     | csr_wr_en/csr_wr_data        | in
//
// A compute beat holds req_stall high while both walks run and while the rsp
// beats go out: each scanned edge goes through issue, read and evaluate, and
// each vertex scans the whole edge store once per pass. Then n rsp beats, one
// per cycle unless rsp_stall holds them. Reset clears the edge count, flags
// and control and sets the vertex count to VertexMax; the edge store needs no
// clearing.
module strongly_connected_components_unit #(
   parameter int MaxVertices = scc_pkg::VertexMax,
   parameter int MaxEdges    = scc_pkg::EdgeMax
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [scc_pkg::VertW-1:0]  req_edge_from,
   input  logic [scc_pkg::VertW-1:0]  req_edge_to,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [scc_pkg::VertW-1:0]  rsp_vertex_index,
   output logic [scc_pkg::VertW-1:0]  rsp_component_id,
   output logic                       rsp_edges_dropped,
   output logic                       rsp_last_result,
   input  logic                       csr_wr_en,
   input  logic [scc_pkg::CountW-1:0] csr_wr_data
);
   import scc_pkg::*;

   logic [CountW-1:0] vcount_ff;
   always_ff @(posedge clock) begin
      if (reset)          vcount_ff <= CountW'(VertexMax);
      else if (csr_wr_en) vcount_ff <= csr_wr_data;
   end

   cmd_type  cmd;
   stat_type stat;
   logic     busy, accept;

   // hold req off while a compute runs
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   scc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && req_kind),
      .rsp_stall(rsp_stall),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   scc_dpath #(.MaxVertices(MaxVertices), .MaxEdges(MaxEdges)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .load         (accept && !req_kind),
      .edge_from    (req_edge_from),
      .edge_to      (req_edge_to),
      .vertex_count (vcount_ff),
      .cmd          (cmd),
      .stat         (stat),
      .vertex_index (rsp_vertex_index),
      .component_id (rsp_component_id),
      .edges_dropped(rsp_edges_dropped),
      .last_result  (rsp_last_result)
   );

`include "strongly_connected_components_unit_assert.svh"

   `SCC_ASSERT_NOW(a_rsp_busy, clock, reset, rsp_valid, busy, "rsp beat while idle")
   `SCC_ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && !rsp_stall && rsp_last_result, !busy, "busy after last beat")
   `SCC_ASSERT_NEXT(a_compute_busy, clock, reset, accept && req_kind, busy, "compute not started")
endmodule

>>> test/strongly_connected_components_unit_tb.sv
// Testbench for strongly_connected_components_unit: loads directed edges, computes
// components and checks each per-vertex beat against an in-bench Kosaraju model.
// Depends on scc_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module strongly_connected_components_unit_tb;
   import scc_pkg::*;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;
   localparam int   STALL_LIMIT  = 200000;   // cycles without any beat
   localparam int   SETTLE       = 8;        // cycles after the last beat

   typedef enum logic [1:0] {ROW_EDGE, ROW_COMPUTE, ROW_TYPED, ROW_COUNT} row_op_type;

   typedef struct {
      row_op_type op;
      logic [6:0] a;      // source vertex, or the vertex count on ROW_COUNT
      logic [5:0] b;      // target vertex
      logic       drop;   // typed dropped flag on ROW_TYPED
   } stim_row_type;

   typedef struct {
      logic [VertW-1:0] vertex;
      logic [VertW-1:0] comp;
      logic             dropped;
      logic             last;
   } label_beat_type;

   logic                clock, reset;
   logic                req_valid, req_stall, req_kind;
   logic [VertW-1:0]    req_edge_from, req_edge_to;
   logic                rsp_valid, rsp_stall;
   logic [VertW-1:0]    rsp_vertex_index, rsp_component_id;
   logic                rsp_edges_dropped, rsp_last_result;
   logic                csr_wr_en;
   logic [CountW-1:0]   csr_wr_data;

   strongly_connected_components_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_edge_from(req_edge_from), .req_edge_to(req_edge_to),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_vertex_index(rsp_vertex_index), .rsp_component_id(rsp_component_id),
      .rsp_edges_dropped(rsp_edges_dropped), .rsp_last_result(rsp_last_result),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Component model: edge store, count register and both DFS passes.
   // ------------------------------------------------------------------
   logic [5:0]  edge_src_mem [EdgeMax];
   logic [5:0]  edge_dst_mem [EdgeMax];
   int          edges_held;
   logic        drop_seen;
   logic [6:0]  count_reg;
   bit          seen      [VertexMax];
   logic [5:0]  finish_ord[VertexMax];
   int          finish_top;
   logic [5:0]  walk_vert [VertexMax];
   int          walk_edge [VertexMax];
   logic [5:0]  label_of  [VertexMax];
   label_beat_type label_q[$];

   function automatic int live_vertices();
      int n;
      n = int'(count_reg);
      if (n < 1) n = 1;
      if (n > VertexMax) n = VertexMax;
      return n;
   endfunction

   // One DFS from root; reverse follows edges backwards and labels what it reaches.
   function automatic void dfs_from(int root, int n, bit reverse, int label);
      int depth, v, e, src, dst;
      bit pushed;
      depth = 1;
      walk_vert[0] = 6'(root);
      walk_edge[0] = 0;
      seen[root] = 1'b1;
      if (reverse) label_of[root] = 6'(label);
      while (depth > 0) begin
         v = int'(walk_vert[depth-1]);
         e = walk_edge[depth-1];
         pushed = 1'b0;
         while (e < edges_held && !pushed) begin
            src = reverse ? int'(edge_dst_mem[e]) : int'(edge_src_mem[e]);
            dst = reverse ? int'(edge_src_mem[e]) : int'(edge_dst_mem[e]);
            e++;
            // skip edges made stale by a lowered count
            if (edge_src_mem[e-1] < n && edge_dst_mem[e-1] < n && src == v && !seen[dst]) begin
               walk_edge[depth-1] = e;
               seen[dst] = 1'b1;
               if (reverse) label_of[dst] = 6'(label);
               if (depth < VertexMax) begin
                  walk_vert[depth] = 6'(dst);
                  walk_edge[depth] = 0;
                  depth++;
               end
               pushed = 1'b1;
            end
         end
         if (!pushed) begin
            depth--;
            if (!reverse && finish_top < VertexMax) begin
               finish_ord[finish_top] = 6'(v);
               finish_top++;
            end
         end
      end
   endfunction

   // Run both passes, queue one beat per vertex (preset labels if typed), then empty the store.
   function automatic void label_components(bit typed, logic typed_drop);
      int n, c, labels;
      label_beat_type beat;
      n = live_vertices();
      labels = 0;
      foreach (seen[i]) seen[i] = 1'b0;
      finish_top = 0;
      for (int v = 0; v < n; v++)
         if (!seen[v]) dfs_from(v, n, 1'b0, 0);
      foreach (seen[i]) seen[i] = 1'b0;
      while (finish_top > 0) begin
         finish_top--;
         c = int'(finish_ord[finish_top]);
         if (c < n && !seen[c]) begin
            dfs_from(c, n, 1'b1, labels);
            labels++;
         end
      end
      for (int v = 0; v < n; v++) begin
         beat.vertex  = 6'(v);
         // with no live edges every vertex stands alone, highest first
         beat.comp    = typed ? 6'(n - 1 - v) : label_of[v];
         beat.dropped = typed ? typed_drop : drop_seen;
         beat.last    = (v == n - 1);
         label_q.insert(label_q.size(), beat);
      end
      edges_held = 0;
      drop_seen  = 1'b0;
   endfunction

   function automatic void store_edge(int a, int b);
      int n;
      n = live_vertices();
      if (a >= n || b >= n || edges_held >= EdgeMax) drop_seen = 1'b1;
      else begin
         edge_src_mem[edges_held] = 6'(a);
         edge_dst_mem[edges_held] = 6'(b);
         edges_held++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Handshake sampling. Settle everything at the falling edge so the rising
   // edge never races the block's own updates.
   // ------------------------------------------------------------------
   logic           req_fire, rsp_fire;
   label_beat_type rsp_seen;
   int             send_idle_pct, recv_stall_pct;
   int             errors = 0;
   int             quiet_cycles;

   always @(negedge clock) begin
      req_fire = req_valid && !req_stall;
      rsp_fire = rsp_valid && !rsp_stall;
      rsp_seen.vertex  = rsp_vertex_index;
      rsp_seen.comp    = rsp_component_id;
      rsp_seen.dropped = rsp_edges_dropped;
      rsp_seen.last    = rsp_last_result;
   end

   // Receiver: stall at the rate of the current phase.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // Check every accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_fire) begin
         if (label_q.size() == 0) begin
            $error("unexpected result beat for vertex %0d", rsp_seen.vertex);
            errors++;
         end else begin
            label_beat_type want;
            want = label_q.pop_front();
            if (rsp_seen.vertex !== want.vertex) begin
               $error("vertex_index: expected %0d, got %0d", want.vertex, rsp_seen.vertex);
               errors++;
            end
            if (rsp_seen.comp !== want.comp) begin
               $error("component_id: expected %0d, got %0d", want.comp, rsp_seen.comp);
               errors++;
            end
            if (rsp_seen.dropped !== want.dropped) begin
               $error("edges_dropped: expected %0d, got %0d", want.dropped, rsp_seen.dropped);
               errors++;
            end
            if (rsp_seen.last !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_seen.last);
               errors++;
            end
         end
      end
   end

   // Watchdog: give up when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // ------------------------------------------------------------------
   // Driver tasks. Each is entered and left right after a rising edge.
   // ------------------------------------------------------------------
   task automatic send_beat(logic kind, logic [5:0] a, logic [5:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_edge_from <= a;
      req_edge_to   <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic add_edge(logic [5:0] a, logic [5:0] b);
      send_beat(KIND_EDGE, a, b);
      store_edge(a, b);
   endtask

   task automatic compute(bit typed, logic typed_drop);
      // edge fields are don't-care on compute: throw noise at them
      send_beat(KIND_COMPUTE, 6'($urandom), 6'($urandom));
      label_components(typed, typed_drop);
   endtask

   // Drain every pending result, let the block settle, then write the count.
   task automatic write_count(logic [6:0] value);
      req_valid <= 1'b0;
      while (label_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      count_reg = value;
   endtask

   // Directed table: extremes, both kinds, the count saturating both ways,
   // out-of-range edges and a count lowered after loading.
   stim_row_type directed[] = '{
      '{ROW_TYPED,   7'd0,   6'd0,  1'b0},   // all singletons after reset, n = 64
      '{ROW_COUNT,   7'd0,   6'd0,  1'b0},   // zero acts as one vertex
      '{ROW_EDGE,    7'd0,   6'd0,  1'b0},   // self loop, kept
      '{ROW_EDGE,    7'd63,  6'd0,  1'b0},   // vertex out of range, dropped
      '{ROW_TYPED,   7'd0,   6'd0,  1'b1},
      '{ROW_COUNT,   7'd127, 6'd0,  1'b0},   // saturates to 64
      '{ROW_EDGE,    7'd0,   6'd63, 1'b0},
      '{ROW_EDGE,    7'd63,  6'd0,  1'b0},
      '{ROW_EDGE,    7'd5,   6'd6,  1'b0},
      '{ROW_EDGE,    7'd6,   6'd7,  1'b0},
      '{ROW_EDGE,    7'd7,   6'd5,  1'b0},
      '{ROW_EDGE,    7'd42,  6'd21, 1'b0},
      '{ROW_COMPUTE, 7'd0,   6'd0,  1'b0},
      '{ROW_COUNT,   7'd8,   6'd0,  1'b0},
      '{ROW_EDGE,    7'd1,   6'd2,  1'b0},
      '{ROW_EDGE,    7'd2,   6'd1,  1'b0},
      '{ROW_EDGE,    7'd3,   6'd4,  1'b0},
      '{ROW_EDGE,    7'd4,   6'd0,  1'b0},
      '{ROW_COUNT,   7'd3,   6'd0,  1'b0},   // lowered: edges on 3 and 4 go stale
      '{ROW_EDGE,    7'd7,   6'd0,  1'b0},   // now out of range
      '{ROW_COMPUTE, 7'd0,   6'd0,  1'b0},
      '{ROW_COUNT,   7'd64,  6'd0,  1'b0},
      '{ROW_EDGE,    7'd21,  6'd42, 1'b0},
      '{ROW_COMPUTE, 7'd0,   6'd0,  1'b0}
   };

   int phase_idle[4]  = '{0, 83, 0, 29};
   int phase_stall[4] = '{0, 0, 83, 29};

   initial begin
      int n, edges;
      req_valid      <= 1'b0;
      req_kind       <= KIND_EDGE;
      req_edge_from  <= '0;
      req_edge_to    <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      reset          <= 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      count_reg      = 7'd64;
      edges_held     = 0;
      drop_seen      = 1'b0;
      foreach (label_of[i]) label_of[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         case (directed[i].op)
            ROW_EDGE:    add_edge(directed[i].a[5:0], directed[i].b);
            ROW_COMPUTE: compute(1'b0, 1'b0);
            ROW_TYPED:   compute(1'b1, directed[i].drop);
            ROW_COUNT:   write_count(directed[i].a);
         endcase
      end

      // Random graphs: mostly small counts with many cycles, a few large ones.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         for (int g = 0; g < 3; g++) begin
            case ($urandom_range(9))
               0:       n = $urandom_range(65, 127);   // saturates high
               1:       n = $urandom_range(33, 64);
               2:       n = (g == 0) ? 0 : 64;
               default: n = $urandom_range(1, 12);
            endcase
            write_count(7'(n));
            edges = $urandom_range(0, 6);
            for (int e = 0; e < edges; e++) begin
               if ($urandom_range(99) < 85 && n > 0)
                  add_edge(6'($urandom_range(0, (n > 64 ? 64 : n) - 1)),
                           6'($urandom_range(0, (n > 64 ? 64 : n) - 1)));
               else
                  add_edge(6'($urandom), 6'($urandom));
            end
            compute(1'b0, 1'b0);
         end
      end

      // Fill the edge store past capacity on a small graph.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_count(7'd4);
      for (int e = 0; e < EdgeMax + 2; e++)
         add_edge(6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)));
      compute(1'b0, 1'b0);

      req_valid <= 1'b0;
      while (label_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
